/* hdl/tpvm_pkg.sv */
// shared constants and types for the two-phase viscosity mixing block
// no dependencies; imported by the top level
package tpvm_pkg;

  // default field widths
  localparam int unsigned VISC_BITS_DEF = 32;
  localparam int unsigned FRAC_BITS_DEF = 16;

  // configuration port
  localparam int unsigned APB_DATA_W = 32;
  localparam int unsigned APB_ADDR_W = 3;
  localparam logic        REG_MIXING_MODE = 1'b0;

  // mixing rule codes
  localparam logic [2:0] MODE_SERIES   = 3'd0;
  localparam logic [2:0] MODE_PARALLEL = 3'd1;
  localparam logic [2:0] MODE_ME1      = 3'd2;
  localparam logic [2:0] MODE_ME2      = 3'd3;
  localparam logic [2:0] MODE_EMT      = 3'd4;
  localparam logic [2:0] MODE_MEAN     = 3'd5;
  localparam logic [2:0] MODE_RESET    = MODE_MEAN;

  // per-request flags that travel beside the arithmetic chains
  typedef struct packed {
    logic [2:0] mode;
    logic       err;
    logic       ov_a;
    logic       ov_b;
  } tpvm_flags_t;

endpackage

/* hdl/tpvm_div_cell.sv */
// one restoring division step: produces one quotient bit per clock
// no package dependencies; used in the divider chains of the top level
module tpvm_div_cell #(
  parameter int unsigned DW = 50,
  parameter int unsigned QB = 33
) (
  input  logic          clk_i,
  input  logic [DW-1:0] rem_i,
  input  logic [DW-1:0] den_i,
  input  logic [QB-1:0] ql_i,
  output logic [DW-1:0] rem_o,
  output logic [DW-1:0] den_o,
  output logic [QB-1:0] ql_o
);

  logic [DW:0]   trial;
  logic          ge;
  logic [DW:0]   diff;
  logic [DW-1:0] rem_d;
  logic [QB-1:0] ql_d;

  // shift in the next dividend bit and try a subtract
  assign trial = {rem_i, ql_i[QB-1]};
  assign ge    = trial >= {1'b0, den_i};
  assign diff  = trial - {1'b0, den_i};
  assign rem_d = ge ? diff[DW-1:0] : trial[DW-1:0];
  assign ql_d  = {ql_i[QB-2:0], ge};

  // stage register
  always_ff @(posedge clk_i) begin
    rem_o <= rem_d;
    den_o <= den_i;
    ql_o  <= ql_d;
  end

endmodule

/* hdl/tpvm_sqrt_cell.sv */
// one digit-by-digit square root step: produces one root bit per clock
// no package dependencies; used in the square root chain of the top level
module tpvm_sqrt_cell #(
  parameter int unsigned RB   = 52,
  parameter int unsigned RADW = 104
) (
  input  logic            clk_i,
  input  logic [RB+1:0]   rem_i,
  input  logic [RB-1:0]   root_i,
  input  logic [RADW-1:0] rad_i,
  output logic [RB+1:0]   rem_o,
  output logic [RB-1:0]   root_o,
  output logic [RADW-1:0] rad_o
);

  logic [RB+3:0] cur;
  logic [RB+3:0] trial;
  logic [RB+3:0] diff;
  logic          ge;

  // bring down two radicand bits and test root*4+1
  assign cur   = {rem_i, rad_i[RADW-1 -: 2]};
  assign trial = {2'b00, root_i, 2'b01};
  assign ge    = cur >= trial;
  assign diff  = cur - trial;

  // stage register
  always_ff @(posedge clk_i) begin
    rem_o  <= ge ? diff[RB+1:0] : cur[RB+1:0];
    root_o <= {root_i[RB-2:0], ge};
    rad_o  <= {rad_i[RADW-3:0], 2'b00};
  end

endmodule

/* hdl/two_phase_viscosity_mixing.sv */
// top level of the two-phase viscosity mixing block
// depends on tpvm_pkg, tpvm_div_cell and tpvm_sqrt_cell
//
// A request (start high while busy is low) may be issued on every clock;
// busy never rises. Each request gives one result, shown on
// mixture_viscosity_o and status_o for a single cycle with done_o high.
// The path runs through four operand stages, a load stage, the square
// root chain (one cell per root bit) and the output register; the two
// divider chains are shorter and are padded to match. Results leave in
// request order and cannot be held off. The rule is chosen by register
// mixing_mode at byte address 0; the user must write it only while no
// request is in flight, which the block itself does not enforce.
module two_phase_viscosity_mixing
  import tpvm_pkg::*;
#(
  parameter int unsigned VISC_BITS = VISC_BITS_DEF,
  parameter int unsigned FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start,
  output logic                   busy,
  input  logic [VISC_BITS-1:0]   liquid_viscosity_i,
  input  logic [VISC_BITS-1:0]   gas_viscosity_i,
  input  logic [FRAC_BITS:0]     mass_fraction_i,
  output logic                   done_o,
  output logic [VISC_BITS-1:0]   mixture_viscosity_o,
  output logic                   status_o,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [APB_ADDR_W-1:0]  paddr,
  input  logic [APB_DATA_W-1:0]  pwdata,
  output logic [APB_DATA_W-1:0]  prdata,
  output logic                   pready
);

  localparam int unsigned VB   = VISC_BITS;
  localparam int unsigned FB   = FRAC_BITS;
  localparam int unsigned PW   = VB + FB;
  localparam int unsigned IW   = PW + 3;
  localparam int unsigned DW   = PW + 2;
  localparam int unsigned NUMW = VB + IW;
  localparam int unsigned QB   = VB + 1;
  localparam int unsigned SW   = PW + 3;
  localparam int unsigned H    = (SW + 1) / 2;
  localparam int unsigned RW   = 2 * SW + 1;
  localparam int unsigned RB   = (RW + 1) / 2;
  localparam int unsigned RADW = 2 * RB;
  localparam int unsigned DPAD = RB - QB;
  localparam logic [FB:0] ONE_F = {1'b1, {FB{1'b0}}};

  // configuration register
  logic [2:0] mode_q;
  logic       cfg_wr;

  assign pready = 1'b1;
  assign busy   = 1'b0;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_MIXING_MODE);
  assign prdata = (paddr[2] == REG_MIXING_MODE) ? APB_DATA_W'(mode_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_RESET;
    end else if (cfg_wr) begin
      mode_q <= pwdata[2:0];
    end
  end

  // stage 1: clamp the fraction and form the basic products
  logic [FB:0]      xs, ys;
  logic [PW:0]      lx_w, ly_w, gx_w, gy_w;
  logic [2*VB-1:0]  lg_w;
  logic             v1_q;
  logic [PW-1:0]    lx1_q, ly1_q, gx1_q, gy1_q;
  logic [2*VB-1:0]  lg1_q;
  logic [VB-1:0]    l1_q, g1_q;
  logic [2:0]       mode1_q;

  assign xs   = (mass_fraction_i > ONE_F) ? ONE_F : mass_fraction_i;
  assign ys   = ONE_F - xs;
  assign lx_w = liquid_viscosity_i * xs;
  assign ly_w = liquid_viscosity_i * ys;
  assign gx_w = gas_viscosity_i * xs;
  assign gy_w = gas_viscosity_i * ys;
  assign lg_w = liquid_viscosity_i * gas_viscosity_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else begin
      v1_q <= start;
    end
  end

  always_ff @(posedge clk_i) begin
    lx1_q   <= lx_w[PW-1:0];
    ly1_q   <= ly_w[PW-1:0];
    gx1_q   <= gx_w[PW-1:0];
    gy1_q   <= gy_w[PW-1:0];
    lg1_q   <= lg_w;
    l1_q    <= liquid_viscosity_i;
    g1_q    <= gas_viscosity_i;
    mode1_q <= mode_q;
  end

  // stage 2: sums for numerators, divisors and the medium-theory term
  logic [PW:0]     sden_w, lygx_w;
  logic [IW-1:0]   a1_w, a2_w;
  logic [DW-1:0]   d1_w, d2_w;
  logic [VB:0]     glsum_w;
  logic [SW-1:0]   p_w, n_w, s_w;
  logic            neg_w;
  logic            v2_q;
  logic [PW:0]     sden2_q;
  logic [VB:0]     par2_q;
  logic [IW-1:0]   a1_2_q, a2_2_q;
  logic [DW-1:0]   d1_2_q, d2_2_q;
  logic [SW-1:0]   s2_q;
  logic            neg2_q;
  logic [2*VB-1:0] lg2_q;
  logic [VB-1:0]   l2_q, g2_q;
  logic [2:0]      mode2_q;

  assign sden_w  = gy1_q + lx1_q;
  assign lygx_w  = ly1_q + gx1_q;
  assign a1_w    = {ly1_q, 1'b0} + {g1_q, {FB{1'b0}}} + {gx1_q, 1'b0};
  assign a2_w    = {gx1_q, 1'b0} + {l1_q, {FB{1'b0}}} + {ly1_q, 1'b0};
  assign d1_w    = {l1_q, {(FB+1){1'b0}}} + lx1_q + gy1_q;
  assign d2_w    = {g1_q, {(FB+1){1'b0}}} + gy1_q + lx1_q;
  assign glsum_w = g1_q + l1_q;
  assign p_w     = {lygx_w, 1'b0} + lygx_w;
  assign n_w     = {glsum_w, {FB{1'b0}}};
  assign neg_w   = p_w < n_w;
  assign s_w     = neg_w ? (n_w - p_w) : (p_w - n_w);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    sden2_q <= sden_w;
    par2_q  <= lygx_w[PW:FB];
    a1_2_q  <= a1_w;
    a2_2_q  <= a2_w;
    d1_2_q  <= d1_w;
    d2_2_q  <= d2_w;
    s2_q    <= s_w;
    neg2_q  <= neg_w;
    lg2_q   <= lg1_q;
    l2_q    <= l1_q;
    g2_q    <= g1_q;
    mode2_q <= mode1_q;
  end

  // stage 3: partial products of the wide multiplications
  logic [2*VB-1:0]       m1lo_w, m2lo_w;
  logic [IW-1:0]         m1hi_w, m2hi_w;
  logic [2*(SW-H)-1:0]   hh_w;
  logic [SW-1:0]         hl_w;
  logic [2*H-1:0]        ll_w;
  logic                  v3_q;
  logic [2*VB-1:0]       m1lo3_q, m2lo3_q;
  logic [IW-1:0]         m1hi3_q, m2hi3_q;
  logic [2*(SW-H)-1:0]   hh3_q;
  logic [SW-1:0]         hl3_q;
  logic [2*H-1:0]        ll3_q;
  logic [PW:0]           sden3_q;
  logic [VB:0]           par3_q;
  logic [DW-1:0]         d1_3_q, d2_3_q;
  logic [SW-1:0]         s3_q;
  logic                  neg3_q;
  logic [2*VB-1:0]       lg3_q;
  logic [2:0]            mode3_q;

  assign m1lo_w = l2_q * a1_2_q[VB-1:0];
  assign m1hi_w = l2_q * a1_2_q[IW-1:VB];
  assign m2lo_w = g2_q * a2_2_q[VB-1:0];
  assign m2hi_w = g2_q * a2_2_q[IW-1:VB];
  assign hh_w   = s2_q[SW-1:H] * s2_q[SW-1:H];
  assign hl_w   = s2_q[SW-1:H] * s2_q[H-1:0];
  assign ll_w   = s2_q[H-1:0] * s2_q[H-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else begin
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    m1lo3_q <= m1lo_w;
    m1hi3_q <= m1hi_w;
    m2lo3_q <= m2lo_w;
    m2hi3_q <= m2hi_w;
    hh3_q   <= hh_w;
    hl3_q   <= hl_w;
    ll3_q   <= ll_w;
    sden3_q <= sden2_q;
    par3_q  <= par2_q;
    d1_3_q  <= d1_2_q;
    d2_3_q  <= d2_2_q;
    s3_q    <= s2_q;
    neg3_q  <= neg2_q;
    lg3_q   <= lg2_q;
    mode3_q <= mode2_q;
  end

  // stage 4: recombine partial products, form the radicand
  logic [NUMW-1:0]  n1_w, n2_w;
  logic [2*SW-1:0]  sq_w;
  logic [RW-1:0]    rad_w;
  logic             v4_q;
  logic [NUMW-1:0]  n1_4_q, n2_4_q;
  logic [RW-1:0]    rad4_q;
  logic [PW:0]      sden4_q;
  logic [VB:0]      par4_q;
  logic [DW-1:0]    d1_4_q, d2_4_q;
  logic [SW-1:0]    s4_q;
  logic             neg4_q;
  logic [2*VB-1:0]  lg4_q;
  logic [2:0]       mode4_q;

  assign n1_w  = m1lo3_q + {m1hi3_q, {VB{1'b0}}};
  assign n2_w  = m2lo3_q + {m2hi3_q, {VB{1'b0}}};
  assign sq_w  = {hh3_q, {(2*H){1'b0}}} + {hl3_q, {(H+1){1'b0}}} + ll3_q;
  assign rad_w = sq_w + {lg3_q, {(2*FB+3){1'b0}}};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
    end else begin
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    n1_4_q  <= n1_w;
    n2_4_q  <= n2_w;
    rad4_q  <= rad_w;
    sden4_q <= sden3_q;
    par4_q  <= par3_q;
    d1_4_q  <= d1_3_q;
    d2_4_q  <= d2_3_q;
    s4_q    <= s3_q;
    neg4_q  <= neg3_q;
    lg4_q   <= lg3_q;
    mode4_q <= mode3_q;
  end

  // stage 5: pick divider operands, check overflow and zero divisors
  logic [NUMW-1:0] num_a_w;
  logic [DW-1:0]   den_a_w;
  logic            ov_a_w, ov_b_w;
  logic            dz_s, dz_1, dz_2;
  tpvm_flags_t     flags_w;

  assign num_a_w = (mode4_q == MODE_SERIES) ? NUMW'({lg4_q, {FB{1'b0}}}) : n1_4_q;
  assign den_a_w = (mode4_q == MODE_SERIES) ? DW'(sden4_q) : d1_4_q;
  assign ov_a_w  = num_a_w[NUMW-1:QB] >= den_a_w;
  assign ov_b_w  = n2_4_q[NUMW-1:QB] >= d2_4_q;
  assign dz_s    = (sden4_q == '0);
  assign dz_1    = (d1_4_q == '0);
  assign dz_2    = (d2_4_q == '0);

  always_comb begin
    flags_w.mode = mode4_q;
    flags_w.ov_a = ov_a_w;
    flags_w.ov_b = ov_b_w;
    unique case (mode4_q)
      MODE_SERIES:   flags_w.err = dz_s;
      MODE_PARALLEL: flags_w.err = 1'b0;
      MODE_ME1:      flags_w.err = dz_1;
      MODE_ME2:      flags_w.err = dz_2;
      MODE_EMT:      flags_w.err = 1'b0;
      default:       flags_w.err = dz_1 | dz_2;
    endcase
  end

  // chain storage: index 0 is the load register, index i+1 follows cell i
  logic [DW-1:0]   a_rem [0:QB];
  logic [DW-1:0]   a_den [0:QB];
  logic [QB-1:0]   a_ql  [0:QB];
  logic [DW-1:0]   b_rem [0:QB];
  logic [DW-1:0]   b_den [0:QB];
  logic [QB-1:0]   b_ql  [0:QB];
  logic [RB+1:0]   r_rem [0:RB];
  logic [RB-1:0]   r_root[0:RB];
  logic [RADW-1:0] r_rad [0:RB];

  // side information running beside the chains
  logic            vld_q  [0:RB];
  tpvm_flags_t     flg_q  [0:RB];
  logic [VB:0]     par_q  [0:RB];
  logic [SW-1:0]   s_q    [0:RB];
  logic            neg_q  [0:RB];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else begin
      vld_q[0] <= v4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    a_rem[0]  <= ov_a_w ? '0 : num_a_w[NUMW-1:QB];
    a_den[0]  <= den_a_w;
    a_ql[0]   <= num_a_w[QB-1:0];
    b_rem[0]  <= ov_b_w ? '0 : n2_4_q[NUMW-1:QB];
    b_den[0]  <= d2_4_q;
    b_ql[0]   <= n2_4_q[QB-1:0];
    r_rem[0]  <= '0;
    r_root[0] <= '0;
    r_rad[0]  <= RADW'(rad4_q);
    flg_q[0]  <= flags_w;
    par_q[0]  <= par4_q;
    s_q[0]    <= s4_q;
    neg_q[0]  <= neg4_q;
  end

  // divider chains, one quotient bit per cell
  for (genvar i = 0; i < QB; i++) begin : g_div
    tpvm_div_cell #(.DW(DW), .QB(QB)) u_div_a (
      .clk_i (clk_i),
      .rem_i (a_rem[i]),
      .den_i (a_den[i]),
      .ql_i  (a_ql[i]),
      .rem_o (a_rem[i+1]),
      .den_o (a_den[i+1]),
      .ql_o  (a_ql[i+1])
    );
    tpvm_div_cell #(.DW(DW), .QB(QB)) u_div_b (
      .clk_i (clk_i),
      .rem_i (b_rem[i]),
      .den_i (b_den[i]),
      .ql_i  (b_ql[i]),
      .rem_o (b_rem[i+1]),
      .den_o (b_den[i+1]),
      .ql_o  (b_ql[i+1])
    );
  end

  // square root chain and side pipeline, one root bit per cell
  for (genvar j = 0; j < RB; j++) begin : g_sqrt
    tpvm_sqrt_cell #(.RB(RB), .RADW(RADW)) u_sqrt (
      .clk_i  (clk_i),
      .rem_i  (r_rem[j]),
      .root_i (r_root[j]),
      .rad_i  (r_rad[j]),
      .rem_o  (r_rem[j+1]),
      .root_o (r_root[j+1]),
      .rad_o  (r_rad[j+1])
    );

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[j+1] <= 1'b0;
      end else begin
        vld_q[j+1] <= vld_q[j];
      end
    end

    always_ff @(posedge clk_i) begin
      flg_q[j+1] <= flg_q[j];
      par_q[j+1] <= par_q[j];
      s_q[j+1]   <= s_q[j];
      neg_q[j+1] <= neg_q[j];
    end
  end

  // pad the quotients to line up with the root
  logic [QB-1:0] pad_a_q [0:DPAD-1];
  logic [QB-1:0] pad_b_q [0:DPAD-1];

  always_ff @(posedge clk_i) begin
    pad_a_q[0] <= a_ql[QB];
    pad_b_q[0] <= b_ql[QB];
  end

  for (genvar k = 1; k < DPAD; k++) begin : g_pad
    always_ff @(posedge clk_i) begin
      pad_a_q[k] <= pad_a_q[k-1];
      pad_b_q[k] <= pad_b_q[k-1];
    end
  end

  // result selection and saturation
  tpvm_flags_t     fl;
  logic [QB-1:0]   qa, qb;
  logic [RB:0]     rsum;
  logic [QB:0]     msum;
  logic [VB+2:0]   val;
  logic            big;
  logic [VB-1:0]   mix_d;
  logic            done_q;
  logic [VB-1:0]   mix_q;
  logic            stat_q;

  assign fl   = flg_q[RB];
  assign qa   = pad_a_q[DPAD-1];
  assign qb   = pad_b_q[DPAD-1];
  assign rsum = neg_q[RB] ? ({1'b0, r_root[RB]} - s_q[RB]) : ({1'b0, r_root[RB]} + s_q[RB]);
  assign msum = qa + qb;

  always_comb begin
    unique case (fl.mode)
      MODE_SERIES, MODE_ME1: begin
        val = (VB+3)'(qa);
        big = fl.ov_a;
      end
      MODE_ME2: begin
        val = (VB+3)'(qb);
        big = fl.ov_b;
      end
      MODE_PARALLEL: begin
        val = (VB+3)'(par_q[RB]);
        big = 1'b0;
      end
      MODE_EMT: begin
        val = rsum[RB:FB+2];
        big = 1'b0;
      end
      default: begin
        val = (VB+3)'(msum[QB:1]);
        big = fl.ov_a | fl.ov_b;
      end
    endcase
  end

  assign mix_d = fl.err ? '0 :
                 (big || (val[VB+2:VB] != '0)) ? '1 : val[VB-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= vld_q[RB];
    end
  end

  always_ff @(posedge clk_i) begin
    mix_q  <= mix_d;
    stat_q <= fl.err;
  end

  assign done_o              = done_q;
  assign mixture_viscosity_o = mix_q;
  assign status_o            = stat_q;

endmodule
